// File: hdl/lps_pkg.sv
`default_nettype none

package lps_pkg;

    localparam int LED_NUM       = 4;
    localparam int PATTERN_DEPTH = 256;
    localparam int QUEUE_DEPTH   = 2;

    localparam int PTR_W     = $clog2(PATTERN_DEPTH);
    localparam int CH_W      = (LED_NUM > 1) ? $clog2(LED_NUM) : 1;
    localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int WORD_W    = 16;
    localparam int PRIO_W    = 8;
    localparam int OUT_LEDS  = 4;
    localparam int SHOW_LEDS = (LED_NUM < OUT_LEDS) ? LED_NUM : OUT_LEDS;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_RUN  = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;
    localparam logic [1:0] KIND_LOAD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STOP_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_CODE = 1'b1;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_RUN,
        OP_STOP,
        OP_LOAD,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic [CH_W-1:0]           chan;
        logic [PTR_W-1:0]          addr;
        logic signed [WORD_W-1:0]  word;
        logic signed [PRIO_W-1:0]  prio;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK_RD,
        S_TICK_CMP,
        S_LOOP_CHK,
        S_STOP_CHK,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: hdl/lps_front.sv
`default_nettype none

module lps_front (
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lps_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [lps_pkg::S_TUSER_W-1:0]    s_tuser,
    input  wire lps_pkg::q_stat_t                 q_stat,
    output logic                                  push,
    output lps_pkg::cmd_t                         push_cmd
);

    logic [1:0]  led_index;
    logic [7:0]  address;
    logic        led_ok;

    assign led_index = s_tdata[1:0];
    assign address   = s_tdata[9:2];
    assign led_ok    = (32'(led_index) < lps_pkg::LED_NUM);

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    always_comb
    begin
        push_cmd.chan = lps_pkg::CH_W'(led_index);
        push_cmd.addr = lps_pkg::PTR_W'(address);
        push_cmd.word = s_tdata[25:10];
        push_cmd.prio = s_tdata[33:26];
        unique case (s_tuser)
            lps_pkg::KIND_TICK: push_cmd.op = lps_pkg::OP_TICK;
            lps_pkg::KIND_RUN:  push_cmd.op = led_ok ? lps_pkg::OP_RUN : lps_pkg::OP_NOP;
            lps_pkg::KIND_STOP: push_cmd.op = led_ok ? lps_pkg::OP_STOP : lps_pkg::OP_NOP;
            lps_pkg::KIND_LOAD: push_cmd.op = lps_pkg::OP_LOAD;
            default:            push_cmd.op = lps_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/lps_queue.sv
`default_nettype none

module lps_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire lps_pkg::cmd_t    push_cmd,
    input  wire logic             pop,
    output lps_pkg::cmd_t         pop_cmd,
    output lps_pkg::q_stat_t      q_stat
);

    lps_pkg::cmd_t                 entry_reg [lps_pkg::QUEUE_DEPTH];
    logic [lps_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [lps_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [lps_pkg::QPTR_W:0]      count_reg, count_next;
    logic                          do_push, do_pop;

    assign q_stat.full      = (count_reg == (lps_pkg::QPTR_W + 1)'(lps_pkg::QUEUE_DEPTH));
    assign q_stat.not_empty = (count_reg != '0);
    assign do_push          = push && !q_stat.full;
    assign do_pop           = pop && q_stat.not_empty;
    assign pop_cmd          = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == lps_pkg::QPTR_W'(lps_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lps_pkg::QPTR_W'(lps_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lps_back.sv
`default_nettype none

module lps_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire lps_pkg::cmd_t                      q_cmd,
    input  wire lps_pkg::q_stat_t                   q_stat,
    output logic                                    pop,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lps_pkg::WORD_W-1:0]         cfg_data,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [lps_pkg::M_TDATA_W-1:0]           m_tdata
);

    localparam int LN = lps_pkg::LED_NUM;
    localparam int PW = lps_pkg::PTR_W;
    localparam int CW = lps_pkg::CH_W;
    localparam int WW = lps_pkg::WORD_W;

    lps_pkg::state_t          state_reg, state_next;
    lps_pkg::cmd_t            cmd_reg, cmd_next;
    logic [CW-1:0]            ch_reg, ch_next;
    logic                     status_reg, status_next;

    logic signed [WW-1:0]     stop_code_reg, stop_code_next;
    logic signed [WW-1:0]     loop_code_reg, loop_code_next;

    logic [PW-1:0]            ptr_reg   [LN];
    logic [PW-1:0]            ptr_next  [LN];
    logic [PW-1:0]            start_reg [LN];
    logic [PW-1:0]            start_next[LN];
    logic signed [WW-1:0]     count_reg [LN];
    logic signed [WW-1:0]     count_next[LN];
    logic [LN-1:0]            playing_reg, playing_next;
    logic [LN-1:0]            claimed_reg, claimed_next;
    logic [LN-1:0]            level_reg, level_next;

    logic                     m_valid_reg, m_valid_next;
    logic [lps_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Pattern store: one write port, one registered read port.
    logic signed [WW-1:0]     store [lps_pkg::PATTERN_DEPTH];
    logic signed [WW-1:0]     rdata_reg;
    logic [PW-1:0]            rd_addr;
    logic                     mem_we;

    logic [CW-1:0]            chan_sel;
    logic [PW-1:0]            cur_ptr;
    logic [PW-1:0]            cur_start;
    logic signed [WW-1:0]     cur_count;
    logic signed [WW-1:0]     count_inc;
    logic                     hit;
    logic                     is_loop;
    logic                     is_stop;
    logic                     ch_last;
    logic                     out_free;
    logic                     prio_gt;
    logic [lps_pkg::OUT_LEDS-1:0] show_level;
    logic [lps_pkg::OUT_LEDS-1:0] show_playing;

    assign chan_sel  = (state_reg == lps_pkg::S_EXEC) ? cmd_reg.chan : ch_reg;
    assign cur_ptr   = ptr_reg[chan_sel];
    assign cur_start = start_reg[chan_sel];
    assign cur_count = count_reg[chan_sel];
    assign count_inc = (cur_count == {1'b0, {(WW-1){1'b1}}}) ? cur_count
                                                               : cur_count + $signed(WW'(1));
    assign hit       = (count_inc >= rdata_reg);
    assign is_loop   = (rdata_reg == loop_code_reg);
    assign is_stop   = (rdata_reg == stop_code_reg);
    assign ch_last   = (ch_reg == CW'(LN - 1));
    assign out_free  = !m_valid_reg || m_tready;
    assign prio_gt   = ($signed({{(WW - lps_pkg::PRIO_W){cmd_reg.prio[lps_pkg::PRIO_W-1]}},
                                 cmd_reg.prio}) > stop_code_reg);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb
    begin
        show_level   = '0;
        show_playing = '0;
        for (int i = 0; i < lps_pkg::SHOW_LEDS; i++)
        begin
            show_level[i]   = level_reg[i];
            show_playing[i] = playing_reg[i];
        end
    end

    // Next read address: the word a channel waits on, then the word after
    // it, then the start word when a loop marker sends the pointer back.
    always_comb
    begin
        unique case (state_reg)
            lps_pkg::S_TICK_CMP: rd_addr = cur_ptr + 1'b1;
            lps_pkg::S_LOOP_CHK: rd_addr = cur_start;
            default:             rd_addr = cur_ptr;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lps_pkg::S_IDLE:
            begin
                if (q_stat.not_empty)
                begin
                    state_next = (q_cmd.op == lps_pkg::OP_TICK) ? lps_pkg::S_TICK_RD
                                                                : lps_pkg::S_EXEC;
                end
            end
            lps_pkg::S_EXEC:
            begin
                state_next = lps_pkg::S_EMIT;
            end
            lps_pkg::S_TICK_RD:
            begin
                if (playing_reg[chan_sel])
                begin
                    state_next = lps_pkg::S_TICK_CMP;
                end
                else if (ch_last)
                begin
                    state_next = lps_pkg::S_EMIT;
                end
            end
            lps_pkg::S_TICK_CMP:
            begin
                if (hit)
                begin
                    state_next = lps_pkg::S_LOOP_CHK;
                end
                else
                begin
                    state_next = ch_last ? lps_pkg::S_EMIT : lps_pkg::S_TICK_RD;
                end
            end
            lps_pkg::S_LOOP_CHK:
            begin
                if (is_loop)
                begin
                    state_next = lps_pkg::S_STOP_CHK;
                end
                else
                begin
                    state_next = ch_last ? lps_pkg::S_EMIT : lps_pkg::S_TICK_RD;
                end
            end
            lps_pkg::S_STOP_CHK:
            begin
                state_next = ch_last ? lps_pkg::S_EMIT : lps_pkg::S_TICK_RD;
            end
            lps_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = lps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lps_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        mem_we         = 1'b0;
        cmd_next       = cmd_reg;
        ch_next        = ch_reg;
        status_next    = status_reg;
        ptr_next       = ptr_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        playing_next   = playing_reg;
        claimed_next   = claimed_reg;
        level_next     = level_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        stop_code_next = stop_code_reg;
        loop_code_next = loop_code_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                lps_pkg::CFG_STOP_CODE: stop_code_next = cfg_data;
                lps_pkg::CFG_LOOP_CODE: loop_code_next = cfg_data;
                default:                stop_code_next = stop_code_reg;
            endcase
        end

        unique case (state_reg)
            lps_pkg::S_IDLE:
            begin
                if (q_stat.not_empty)
                begin
                    pop         = 1'b1;
                    cmd_next    = q_cmd;
                    ch_next     = '0;
                    status_next = 1'b0;
                end
            end
            lps_pkg::S_EXEC:
            begin
                unique case (cmd_reg.op)
                    lps_pkg::OP_RUN:
                    begin
                        level_next[chan_sel] = 1'b1;
                        if (claimed_reg[chan_sel])
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            claimed_next[chan_sel] = 1'b1;
                            ptr_next[chan_sel]     = cmd_reg.addr;
                            start_next[chan_sel]   = cmd_reg.addr;
                            playing_next[chan_sel] = prio_gt;
                        end
                    end
                    lps_pkg::OP_STOP:
                    begin
                        playing_next[chan_sel] = 1'b0;
                        claimed_next[chan_sel] = 1'b0;
                        level_next[chan_sel]   = 1'b0;
                    end
                    lps_pkg::OP_LOAD:
                    begin
                        mem_we = 1'b1;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            lps_pkg::S_TICK_RD:
            begin
                if (!playing_reg[chan_sel] && !ch_last)
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            lps_pkg::S_TICK_CMP:
            begin
                if (hit)
                begin
                    level_next[chan_sel] = !level_reg[chan_sel];
                    count_next[chan_sel] = '0;
                    ptr_next[chan_sel]   = cur_ptr + 1'b1;
                end
                else
                begin
                    count_next[chan_sel] = count_inc;
                    if (!ch_last)
                    begin
                        ch_next = ch_reg + 1'b1;
                    end
                end
            end
            lps_pkg::S_LOOP_CHK:
            begin
                if (is_loop)
                begin
                    ptr_next[chan_sel] = cur_start;
                end
                else
                begin
                    if (is_stop)
                    begin
                        playing_next[chan_sel] = 1'b0;
                        claimed_next[chan_sel] = 1'b0;
                        level_next[chan_sel]   = 1'b0;
                    end
                    if (!ch_last)
                    begin
                        ch_next = ch_reg + 1'b1;
                    end
                end
            end
            lps_pkg::S_STOP_CHK:
            begin
                if (is_stop)
                begin
                    playing_next[chan_sel] = 1'b0;
                    claimed_next[chan_sel] = 1'b0;
                    level_next[chan_sel]   = 1'b0;
                end
                if (!ch_last)
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            lps_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, status_reg, show_playing, show_level};
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lps_pkg::S_IDLE;
            ch_reg        <= '0;
            status_reg    <= 1'b0;
            stop_code_reg <= '0;
            loop_code_reg <= '1;
            playing_reg   <= '0;
            claimed_reg   <= '0;
            level_reg     <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < LN; i++)
            begin
                ptr_reg[i]   <= '0;
                start_reg[i] <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            status_reg    <= status_next;
            stop_code_reg <= stop_code_next;
            loop_code_reg <= loop_code_next;
            playing_reg   <= playing_next;
            claimed_reg   <= claimed_next;
            level_reg     <= level_next;
            m_valid_reg   <= m_valid_next;
            ptr_reg       <= ptr_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[cmd_reg.addr] <= cmd_reg.word;
        end
        rdata_reg <= store[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/led_pattern_sequencer_top.sv
// Channel    Dir   Handshake              Payload
// s_axis     in    s_tvalid / s_tready    s_tuser kind; s_tdata led, address, word, priority
// m_axis     out   m_tvalid / m_tready    m_tdata levels, playing mask, status
// cfg        in    cfg_valid / cfg_ready  cfg_index, cfg_data (0 stop code, 1 loop code)
//
// Popped run, stop and load items reach the result register via S_EXEC and S_EMIT.
// A tick walks the channels one at a time, bounded by the store's single read port:
// S_TICK_RD only for a channel that is not playing, then S_TICK_CMP when it plays,
// S_LOOP_CHK on a step and S_STOP_CHK when a loop word sends the pointer back.
// Reset clears all channel state and sets the stop code to 0 and the loop code to -1;
// the store is not cleared.
// Input transactions are buffered in a two-entry queue, so the front keeps accepting
// while a result waits on m_tready, until both entries are taken.
`default_nettype none

module led_pattern_sequencer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [1:0] led_index, [9:2] address, [25:10] word_value, [33:26] priority_req
    input  wire logic [lps_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] kind
    input  wire logic [lps_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [3:0] led_levels, [7:4] playing_mask, [8] status
    output logic [lps_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lps_pkg::WORD_W-1:0]       cfg_data
);

    lps_pkg::cmd_t     push_cmd;
    lps_pkg::cmd_t     pop_cmd;
    lps_pkg::q_stat_t  q_stat;
    logic              push;
    logic              pop;

    lps_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    lps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (pop_cmd),
        .q_stat    (q_stat),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// File: hdl/lps_checker.sv
`default_nettype none

module lps_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [lps_pkg::M_TDATA_W-1:0]    m_tdata
);

    // A result cannot reach the output register before an item queued after reset
    // is released has been popped and emitted, since nothing is queued before then.
    a_quiet_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
        else $error("result presented too soon after reset");

    a_idle_in_reset: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result presented during reset");

    // The queue is empty in reset, so the input side reports ready.
    a_ready_in_reset: assert property (@(posedge clk)
        !rst_n |-> s_tready)
        else $error("input not ready during reset");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before its transaction");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind led_pattern_sequencer_top lps_checker u_lps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/led_pattern_sequencer_top_test.sv
`timescale 1ns / 100ps

module led_pattern_sequencer_top_test;

    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASE_ITEMS = 170;
    localparam int LONG_HOLD   = 80;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         led;
        logic [7:0]         addr;
        logic signed [15:0] word;
        logic signed [7:0]  prio;
    } led_cmd_t;

    typedef struct packed {
        logic [3:0] levels;
        logic [3:0] mask;
        logic       status;
    } led_status_t;

    typedef struct packed {
        led_cmd_t    cmd;
        logic        typed;
        led_status_t want;
    } dir_row_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [lps_pkg::S_TDATA_W-1:0]        s_tdata;
    logic [lps_pkg::S_TUSER_W-1:0]        s_tuser;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [lps_pkg::M_TDATA_W-1:0]        m_tdata;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [lps_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [lps_pkg::WORD_W-1:0]           cfg_data;

    // Mirror of the sequencer state.
    logic signed [15:0] pat_mem [256];
    bit                 pat_written [256];
    logic [7:0]         seq_ptr [4];
    logic [7:0]         seq_base [4];
    int                 tick_cnt [4];
    bit                 chan_play [4];
    bit                 chan_claim [4];
    bit                 chan_level [4];
    logic signed [15:0] stop_word;
    logic signed [15:0] loop_word;

    led_status_t pending_leds [$];
    dir_row_t    dir_rows [$];

    int errors;
    int items_sent;
    int cycles;
    int stall_left;
    bit hold_req;
    bit calm;

    led_pattern_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void release_led(int i);
        chan_play[i]  = 1'b0;
        chan_claim[i] = 1'b0;
        chan_level[i] = 1'b0;
    endfunction

    function automatic void advance_led(int i);
        int c;
        if (!chan_play[i])
            return;
        c = tick_cnt[i] + 1;
        if (c > 32767)
            c = 32767;
        tick_cnt[i] = c;
        if (c < int'(pat_mem[seq_ptr[i]]))
            return;
        chan_level[i] = !chan_level[i];
        tick_cnt[i] = 0;
        seq_ptr[i] = seq_ptr[i] + 8'd1;
        if (pat_mem[seq_ptr[i]] == loop_word)
            seq_ptr[i] = seq_base[i];
        if (pat_mem[seq_ptr[i]] == stop_word)
            release_led(i);
    endfunction

    function automatic led_status_t sequencer_step(led_cmd_t c);
        led_status_t r;
        r = '0;
        case (c.kind)
            lps_pkg::KIND_TICK:
                for (int i = 0; i < 4; i++)
                    advance_led(i);
            lps_pkg::KIND_RUN:
            begin
                chan_level[c.led] = 1'b1;
                if (chan_claim[c.led])
                    r.status = 1'b1;
                else
                begin
                    chan_claim[c.led] = 1'b1;
                    seq_ptr[c.led]    = c.addr;
                    seq_base[c.led]   = c.addr;
                    chan_play[c.led]  = int'(c.prio) > int'(stop_word);
                end
            end
            lps_pkg::KIND_STOP:
                release_led(c.led);
            default:
            begin
                pat_mem[c.addr]     = c.word;
                pat_written[c.addr] = 1'b1;
            end
        endcase
        for (int i = 0; i < 4; i++)
        begin
            r.levels[i] = chan_level[i];
            r.mask[i]   = chan_play[i];
        end
        return r;
    endfunction

    // Address of a store entry that the next tick would read before it was ever
    // written, or -1 when the tick is safe.
    function automatic int unwritten_read();
        int         c;
        logic [7:0] nx;
        for (int i = 0; i < 4; i++)
        begin
            if (chan_play[i])
            begin
                if (!pat_written[seq_ptr[i]])
                    return int'(seq_ptr[i]);
                c = (tick_cnt[i] >= 32767) ? 32767 : tick_cnt[i] + 1;
                if (c >= int'(pat_mem[seq_ptr[i]]))
                begin
                    nx = seq_ptr[i] + 8'd1;
                    if (!pat_written[nx])
                        return int'(nx);
                    if (pat_mem[nx] == loop_word && !pat_written[seq_base[i]])
                        return int'(seq_base[i]);
                end
            end
        end
        return -1;
    endfunction

    function automatic logic signed [15:0] duration_word();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return 16'($urandom_range(0, 4));
        else if (pick < 16)
            return -$signed(16'($urandom_range(1, 300)));
        else if (pick < 18)
            return 16'($urandom);
        else if (pick == 18)
            return 16'sh7fff;
        return 16'sh8000;
    endfunction

    function automatic logic signed [7:0] run_priority();
        int lo;
        lo = int'(stop_word) + 1;
        if (lo < -128)
            lo = -128;
        if (lo <= 127 && $urandom_range(0, 4) != 0)
            return 8'(lo + $urandom_range(0, 127 - lo));
        return 8'($urandom);
    endfunction

    function automatic dir_row_t mk_row(logic [1:0] kind, logic [1:0] led, logic [7:0] addr,
                                        logic signed [15:0] word, logic signed [7:0] prio,
                                        logic typed, logic [3:0] levels, logic [3:0] mask,
                                        logic status);
        dir_row_t r;
        r.cmd.kind    = kind;
        r.cmd.led     = led;
        r.cmd.addr    = addr;
        r.cmd.word    = word;
        r.cmd.prio    = prio;
        r.typed       = typed;
        r.want.levels = levels;
        r.want.mask   = mask;
        r.want.status = status;
        return r;
    endfunction

    task automatic issue_cmd(input led_cmd_t c, input logic typed, input led_status_t want);
        led_status_t predicted;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= c.kind;
        s_tdata  <= {6'd0, c.prio, c.word, c.addr, c.led};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = sequencer_step(c);
        pending_leds.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Ticks that would read a never-written entry turn into a load of that entry.
    task automatic offer_cmd(input led_cmd_t c);
        int miss;
        if (c.kind == lps_pkg::KIND_TICK)
        begin
            miss = unwritten_read();
            if (miss >= 0)
            begin
                c.kind = lps_pkg::KIND_LOAD;
                c.addr = 8'(miss);
                c.word = duration_word();
            end
        end
        issue_cmd(c, 1'b0, '0);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_leds.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [lps_pkg::CFG_IDX_W-1:0] idx,
                             input logic signed [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == lps_pkg::CFG_STOP_CODE)
            stop_word = val;
        else
            loop_word = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Load a short blink sequence, start an LED on it and let it play for a while,
    // with the odd unrelated transaction mixed in.
    task automatic play_sequence();
        led_cmd_t   c;
        logic [7:0] base;
        int         len;
        int         pick;
        int         ticks;
        base = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(250, 255)) : 8'($urandom);
        len  = $urandom_range(1, 5);
        c    = '0;
        c.kind = lps_pkg::KIND_LOAD;
        for (int j = 0; j <= len; j++)
        begin
            c.addr = base + 8'(j);
            c.word = duration_word();
            if (j == len)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 9)
                    c.word = loop_word;
                else if (pick < 16)
                    c.word = stop_word;
            end
            offer_cmd(c);
        end
        c.led = 2'($urandom);
        if (chan_claim[c.led] && $urandom_range(0, 1) == 1)
        begin
            c.kind = lps_pkg::KIND_STOP;
            offer_cmd(c);
        end
        c.kind = lps_pkg::KIND_RUN;
        c.addr = base;
        c.prio = run_priority();
        offer_cmd(c);
        ticks = $urandom_range(4, 20);
        for (int j = 0; j < ticks; j++)
        begin
            c = 36'({$urandom, $urandom});
            if ($urandom_range(0, 9) != 0)
                c.kind = lps_pkg::KIND_TICK;
            offer_cmd(c);
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        led_status_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_leds.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                exp_r = pending_leds.pop_front();
                check_field("led_levels", int'(exp_r.levels), int'(m_tdata[3:0]));
                check_field("playing_mask", int'(exp_r.mask), int'(m_tdata[7:4]));
                check_field("status", int'(exp_r.status), int'(m_tdata[8]));
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int       phase_start;
        bit       held;
        bit       paused;
        led_cmd_t c;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        errors     = 0;
        items_sent = 0;
        cycles     = 0;
        stall_left = 0;
        hold_req   = 1'b0;
        calm       = 1'b0;
        held       = 1'b0;
        paused     = 1'b0;

        stop_word = 16'sd0;
        loop_word = -16'sd1;
        for (int i = 0; i < 256; i++)
        begin
            pat_mem[i]     = '0;
            pat_written[i] = 1'b0;
        end
        for (int i = 0; i < 4; i++)
        begin
            seq_ptr[i]  = '0;
            seq_base[i] = '0;
            tick_cnt[i] = 0;
            release_led(i);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Idle tick, stop of an unclaimed LED, busy runs, a run that does not play,
        // a start that wraps past the top of the store, a loop word, and a stop word
        // right after the first step.
        dir_rows.push_back(mk_row(lps_pkg::KIND_TICK, 2'd0, 8'd0, 16'sd0, 8'sd0, 1,
                                  4'b0000, 4'b0000, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_STOP, 2'd3, 8'd0, 16'sd0, 8'sd0, 1,
                                  4'b0000, 4'b0000, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_LOAD, 2'd0, 8'd0, 16'sd2, 8'sd0, 0,
                                  '0, '0, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_LOAD, 2'd0, 8'd1, 16'sd1, 8'sd0, 0,
                                  '0, '0, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_LOAD, 2'd0, 8'd2, -16'sd1, 8'sd0, 0,
                                  '0, '0, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_LOAD, 2'd0, 8'd254, 16'sd1, 8'sd0, 0,
                                  '0, '0, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_LOAD, 2'd0, 8'd255, 16'sd1, 8'sd0, 0,
                                  '0, '0, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_LOAD, 2'd0, 8'd128, 16'sh8000, 8'sd0, 0,
                                  '0, '0, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_LOAD, 2'd0, 8'd129, 16'sd0, 8'sd0, 0,
                                  '0, '0, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_LOAD, 2'd3, 8'd200, 16'sh7fff, 8'sd0, 0,
                                  '0, '0, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_RUN, 2'd0, 8'd0, 16'sd0, 8'sd127, 1,
                                  4'b0001, 4'b0001, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_RUN, 2'd0, 8'd5, 16'sd0, 8'sd1, 1,
                                  4'b0001, 4'b0001, 1));
        dir_rows.push_back(mk_row(lps_pkg::KIND_RUN, 2'd1, 8'd200, 16'sd0, 8'sh80, 1,
                                  4'b0011, 4'b0001, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_RUN, 2'd1, 8'd0, 16'sd0, 8'sd127, 1,
                                  4'b0011, 4'b0001, 1));
        dir_rows.push_back(mk_row(lps_pkg::KIND_RUN, 2'd2, 8'd254, 16'sd0, 8'sd0, 1,
                                  4'b0111, 4'b0001, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_STOP, 2'd2, 8'd0, 16'sd0, 8'sd0, 1,
                                  4'b0011, 4'b0001, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_RUN, 2'd2, 8'd254, 16'sd0, 8'sd1, 0,
                                  '0, '0, 0));
        dir_rows.push_back(mk_row(lps_pkg::KIND_RUN, 2'd3, 8'd128, 16'sd0, 8'sd5, 0,
                                  '0, '0, 0));
        for (int j = 0; j < 6; j++)
            dir_rows.push_back(mk_row(lps_pkg::KIND_TICK, 2'd0, 8'd0, 16'sd0, 8'sd0, 0,
                                      '0, '0, 0));

        foreach (dir_rows[j])
            issue_cmd(dir_rows[j].cmd, dir_rows[j].typed, dir_rows[j].want);

        for (int p = 1; p <= 4; p++)
        begin
            wait_drained();
            case (p)
                1:
                begin
                    write_reg(lps_pkg::CFG_STOP_CODE, 16'sh8000);
                    write_reg(lps_pkg::CFG_LOOP_CODE, 16'sh7fff);
                end
                2:
                begin
                    write_reg(lps_pkg::CFG_STOP_CODE, 16'sh7fff);
                    write_reg(lps_pkg::CFG_LOOP_CODE, 16'sh8000);
                end
                3:
                begin
                    write_reg(lps_pkg::CFG_STOP_CODE, 16'($urandom_range(0, 8)) - 16'sd3);
                    write_reg(lps_pkg::CFG_LOOP_CODE, 16'($urandom_range(0, 8)) - 16'sd4);
                end
                default:
                begin
                    // The last part runs with no random gaps on either side.
                    calm = 1'b1;
                    write_reg(lps_pkg::CFG_STOP_CODE, 16'sd0);
                    write_reg(lps_pkg::CFG_LOOP_CODE, -16'sd1);
                end
            endcase
            phase_start = items_sent;
            while (items_sent < phase_start + PHASE_ITEMS)
            begin
                if (p == 1 && !held && items_sent > phase_start + 40)
                begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                if (p == 3 && !paused && items_sent > phase_start + 60)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                play_sequence();
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_leds.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
